@@ src/fnv1a64_canonical_key_hash_unit_macros.svh @@
// ----------------------------------------------------------------------------
// FNV-1a key hash assertion macros
// Shared concurrent assertion forms clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FNV1A64_CANONICAL_KEY_HASH_UNIT_MACROS_SVH
`define FNV1A64_CANONICAL_KEY_HASH_UNIT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define FKH_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define FKH_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FKH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fkh_pkg.sv @@
// ----------------------------------------------------------------------------
// FNV-1a key hash package
// Constants, element kinds, controller states and the datapath control bundle.
// ----------------------------------------------------------------------------
package fkh_pkg;

  localparam logic [63:0] FNV_BASIS     = 64'hcbf29ce484222325;
  localparam logic [63:0] DBL_CANON_NAN = 64'h7ff8000000000000;
  localparam logic [63:0] DBL_INF_MAG   = 64'h7ff0000000000000;
  localparam logic [31:0] SGL_CANON_NAN = 32'h7fc00000;
  localparam logic [31:0] SGL_INF_MAG   = 32'h7f800000;

  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_KIND = 2'd1;

  localparam logic [2:0] KIND_RESET = 3'd5;

  typedef enum logic [2:0] {
    KIND_BYTE   = 3'd0,
    KIND_INT16  = 3'd1,
    KIND_INT32  = 3'd2,
    KIND_INT64  = 3'd3,
    KIND_SINGLE = 3'd4,
    KIND_DOUBLE = 3'd5
  } fkh_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MIX  = 2'd1,
    ST_EMIT = 2'd2
  } fkh_state_t;

  typedef struct packed {
    logic load;
    logic load_seed;
    logic step;
  } fkh_ctl_t;

endpackage

@@ src/fnv1a64_canonical_key_hash_unit.sv @@
// ----------------------------------------------------------------------------
// FNV-1a 64-bit canonical key hash unit
// Flow: an accepted element of N bytes (1, 2, 4 or 8 by element kind) is
// mixed one byte per cycle through the single mixing stage, then a closing
// element passes through the emit state into the output register; an empty
// key goes straight to emit. No new element is taken until the last is mixed
// and any result loaded; a result stalled at the output holds the emit state.
// Synchronous active-low reset: no key open, seed = offset basis, kind double.
// ----------------------------------------------------------------------------
`include "fnv1a64_canonical_key_hash_unit_macros.svh"

module fnv1a64_canonical_key_hash_unit import fkh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_element,
  input  logic        in_last,
  input  logic        in_empty_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  fkh_state_t  state_r, state_nxt;
  logic [63:0] seed_r, seed_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt;
  logic        in_key_r, in_key_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;
  logic        accept;
  logic        out_load;
  fkh_ctl_t    ctl;
  logic [7:0]  cur_byte;
  logic [63:0] run_hash;
  logic [3:0]  nbytes;

  always_comb begin
    unique case (kind_r)
      KIND_BYTE:   nbytes = 4'd1;
      KIND_INT16:  nbytes = 4'd2;
      KIND_INT32:  nbytes = 4'd4;
      KIND_SINGLE: nbytes = 4'd4;
      default:     nbytes = 4'd8;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = in_empty_key ? ST_EMIT : ST_MIX;
        end
      end
      ST_MIX: begin
        if (cnt_r == 4'd1) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_load      = 1'b0;
    ctl.load      = 1'b0;
    ctl.load_seed = 1'b0;
    ctl.step      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        ctl.load      = in_valid;
        ctl.load_seed = in_valid && (in_empty_key || !in_key_r);
      end
      ST_MIX: begin
        ctl.step = 1'b1;
      end
      ST_EMIT: begin
        out_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    seed_nxt = seed_r;
    kind_nxt = kind_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED: seed_nxt = cfg_wdata;
        REG_KIND: kind_nxt = cfg_wdata[2:0];
        default:  seed_nxt = seed_r;
      endcase
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    in_key_nxt = in_key_r;
    if (accept) begin
      cnt_nxt  = nbytes;
      last_nxt = in_last;
      if (in_empty_key) begin
        in_key_nxt = 1'b0;
      end
    end else if (state_r == ST_MIX) begin
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        in_key_nxt = !last_r;
      end
    end
  end

  always_comb begin
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_hash_nxt  = run_hash;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= FNV_BASIS;
      kind_r      <= KIND_RESET;
      cnt_r       <= 4'd0;
      last_r      <= 1'b0;
      in_key_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      kind_r      <= kind_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      in_key_r    <= in_key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hash_r <= out_hash_nxt;
  end

  fkh_byte_sreg u_sreg (
    .clk      (clk),
    .ctl      (ctl),
    .kind     (kind_r),
    .element  (in_element),
    .byte_out (cur_byte)
  );

  fkh_mix u_mix (
    .clk     (clk),
    .ctl     (ctl),
    .seed    (seed_r),
    .byte_in (cur_byte),
    .hash    (run_hash)
  );

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;

  `FKH_ASSERT_IMPLIES(a_mix_cnt, state_r == ST_MIX, cnt_r != 4'd0, "Byte count ran out while mixing.")
  `FKH_ASSERT_NEXT(a_open_key, state_r == ST_MIX && cnt_r == 4'd1 && !last_r, state_r == ST_IDLE && in_key_r, "Element without last did not leave the key open.")
  `FKH_ASSERT_NEXT(a_hold_emit, state_r == ST_EMIT && out_valid_r && !out_ready, state_r == ST_EMIT, "Pending result dropped while output was stalled.")
  `FKH_ASSERT_NEXT(a_empty_key, accept && in_empty_key, state_r == ST_EMIT && !in_key_r && run_hash == $past(seed_r), "Empty key did not close with the seed.")

endmodule

@@ src/fkh_byte_sreg.sv @@
// ----------------------------------------------------------------------------
// FNV-1a key hash byte shift register
// Canonicalizes an element on load and presents it one byte per step, LSB first.
// ----------------------------------------------------------------------------
module fkh_byte_sreg import fkh_pkg::*; (
  input  logic        clk,
  input  fkh_ctl_t    ctl,
  input  logic [2:0]  kind,
  input  logic [63:0] element,
  output logic [7:0]  byte_out
);

  logic [63:0] data_r;
  logic [63:0] data_nxt;
  logic [63:0] canon;
  logic [62:0] dmag;
  logic [30:0] smag;

  always_comb begin
    dmag  = element[62:0];
    smag  = element[30:0];
    canon = element;
    unique case (kind)
      KIND_SINGLE: begin
        if ({1'b0, smag} > SGL_INF_MAG) begin
          canon = {32'd0, SGL_CANON_NAN};
        end else if (smag == 31'd0) begin
          canon = 64'd0;
        end else begin
          canon = {32'd0, element[31:0]};
        end
      end
      KIND_DOUBLE: begin
        if ({1'b0, dmag} > DBL_INF_MAG) begin
          canon = DBL_CANON_NAN;
        end else if (dmag == 63'd0) begin
          canon = 64'd0;
        end
      end
      default: canon = element;
    endcase
  end

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = canon;
    end else if (ctl.step) begin
      data_nxt = {8'd0, data_r[63:8]};
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign byte_out = data_r[7:0];

endmodule

@@ src/fkh_mix.sv @@
// ----------------------------------------------------------------------------
// FNV-1a key hash mixing unit
// Running hash register; folds in one sign-extended byte per step.
// ----------------------------------------------------------------------------
module fkh_mix import fkh_pkg::*; (
  input  logic        clk,
  input  fkh_ctl_t    ctl,
  input  logic [63:0] seed,
  input  logic [7:0]  byte_in,
  output logic [63:0] hash
);

  logic [63:0] h_r;
  logic [63:0] h_nxt;
  logic [63:0] x;
  logic [63:0] prod;

  // The prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
  always_comb begin
    x    = h_r ^ {{56{byte_in[7]}}, byte_in};
    prod = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  end

  always_comb begin
    h_nxt = h_r;
    if (ctl.load_seed) begin
      h_nxt = seed;
    end else if (ctl.step) begin
      h_nxt = prod;
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
  end

  assign hash = h_r;

endmodule
